/* hw/rtl/otsu_pkg.sv */
package otsu_pkg;

  localparam int MAX_PIXELS_LOG2 = 24;
  localparam int CNT_W    = MAX_PIXELS_LOG2 + 1;
  localparam int SUM_W    = MAX_PIXELS_LOG2 + 8;
  localparam int BIN_W    = 8;
  localparam int NUM_BINS = 256;
  localparam int XY_W     = SUM_W + CNT_W;
  localparam int NUM_W    = 2 * XY_W;
  localparam int DEN_W    = 2 * CNT_W;
  localparam int MA_W     = NUM_W;
  localparam int MB_W     = XY_W;
  localparam int MP_W     = MA_W + MB_W;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = 2;
  localparam int ADDR_W   = 4;

  localparam logic [BIN_W-1:0] FALLBACK_T = 8'd180;

  localparam logic [1:0] REG_ALPHA_FLOOR   = 2'd0;
  localparam logic [1:0] REG_CLAMP_LOW     = 2'd1;
  localparam logic [1:0] REG_CLAMP_HIGH    = 2'd2;
  localparam logic [1:0] REG_EMPTY_DEFAULT = 2'd3;

  localparam logic [7:0] RST_ALPHA_FLOOR   = 8'd8;
  localparam logic [7:0] RST_CLAMP_LOW     = 8'd72;
  localparam logic [7:0] RST_CLAMP_HIGH    = 8'd220;
  localparam logic [7:0] RST_EMPTY_DEFAULT = 8'd180;

  typedef struct packed {
    logic [BIN_W-1:0] lum;
    logic             vis;
    logic             last;
  } qent_t;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [MP_W-1:0] p;
  } mul_rsp_t;

endpackage

/* hw/rtl/otsu_threshold_visible_pixels.sv */
// Pixel path: one pixel per cycle while not full; visible and last pixels enter a 4-entry
// queue, and a popped entry is registered before its histogram bin is written. Per image:
// after the last pixel the shift-add multiplier search runs over up to 256 bins, with
// multiplies for each scored bin; the queue stalls input (full) once it fills.
// The result register holds until popped.
// Reset (rst_n low, synchronous): registers to defaults, histogram valid bits cleared.
module otsu_threshold_visible_pixels import otsu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_blue,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_alpha,
  input  logic              in_last,
  input  logic              push,
  output logic              full,
  output logic [7:0]        out_threshold,
  output logic [CNT_W-1:0]  out_visible_count,
  output logic              out_empty_res,
  output logic              empty,
  input  logic              pop,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0] alpha_floor_r;
  logic [7:0] clamp_low_r;
  logic [7:0] clamp_high_r;
  logic [7:0] empty_default_r;
  logic       cfg_we;
  logic       accept;
  logic       q_push;
  qent_t      q_wdata;
  qent_t      q_head;
  logic       q_empty;
  logic       q_pop;
  mul_req_t   mreq;
  mul_rsp_t   mrsp;
  logic       out_vld;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign accept = push && !full;
  assign empty  = !out_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_floor_r   <= RST_ALPHA_FLOOR;
      clamp_low_r     <= RST_CLAMP_LOW;
      clamp_high_r    <= RST_CLAMP_HIGH;
      empty_default_r <= RST_EMPTY_DEFAULT;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_ALPHA_FLOOR:   alpha_floor_r   <= pwdata[7:0];
        REG_CLAMP_LOW:     clamp_low_r     <= pwdata[7:0];
        REG_CLAMP_HIGH:    clamp_high_r    <= pwdata[7:0];
        REG_EMPTY_DEFAULT: empty_default_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ALPHA_FLOOR:   prdata = {24'd0, alpha_floor_r};
      REG_CLAMP_LOW:     prdata = {24'd0, clamp_low_r};
      REG_CLAMP_HIGH:    prdata = {24'd0, clamp_high_r};
      REG_EMPTY_DEFAULT: prdata = {24'd0, empty_default_r};
      default:           prdata = '0;
    endcase
  end

  otsu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .blue        (in_blue),
    .green       (in_green),
    .red         (in_red),
    .alpha       (in_alpha),
    .last        (in_last),
    .alpha_floor (alpha_floor_r),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  otsu_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .q_empty (q_empty)
  );

  otsu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  otsu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_head        (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .clamp_low     (clamp_low_r),
    .clamp_high    (clamp_high_r),
    .empty_default (empty_default_r),
    .mreq          (mreq),
    .mrsp          (mrsp),
    .out_vld       (out_vld),
    .out_pop       (pop),
    .out_thr       (out_threshold),
    .out_cnt       (out_visible_count),
    .out_emp       (out_empty_res)
  );

endmodule

/* hw/rtl/otsu_fifo.sv */
module otsu_fifo import otsu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  qent_t wr_data,
  output logic  q_full,
  input  logic  rd_en,
  output qent_t rd_data,
  output logic  q_empty
);

  qent_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r;
  logic [Q_AW-1:0] rp_r;
  logic [Q_AW:0]   cnt_r;

  assign q_full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (Q_AW+1)'(wr_en) - (Q_AW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

/* hw/rtl/otsu_front.sv */
module otsu_front import otsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  input  logic [7:0] alpha,
  input  logic       last,
  input  logic [7:0] alpha_floor,
  output logic       q_push,
  output qent_t      q_data
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [15:0]      wsum;
  logic             vis;

  assign wsum = ({8'd0, red} * 16'd77) + ({8'd0, green} * 16'd150) +
                ({8'd0, blue} * 16'd29) + 16'd128;
  assign vis  = (alpha >= alpha_floor) && (cnt_r < (CNT_W'(1) << MAX_PIXELS_LOG2));

  assign q_push      = accept && (vis || last);
  assign q_data.lum  = wsum[15:8];
  assign q_data.vis  = vis;
  assign q_data.last = last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (last) cnt_nxt = '0;
      else if (vis) cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

endmodule

/* hw/rtl/otsu_mul.sv */
module otsu_mul import otsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic            busy_r;
  logic [MP_W-1:0] acc_r;
  logic [MP_W-1:0] a_r;
  logic [MB_W-1:0] b_r;

  assign rsp.busy = busy_r;
  assign rsp.done = busy_r && (b_r == '0);
  assign rsp.p    = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start && !busy_r) begin
      busy_r <= 1'b1;
    end else if (busy_r && (b_r == '0)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      acc_r <= '0;
      a_r   <= {{MB_W{1'b0}}, req.a};
      b_r   <= req.b;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

endmodule

/* hw/rtl/otsu_back.sv */
module otsu_back import otsu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  qent_t            q_head,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic [7:0]       clamp_low,
  input  logic [7:0]       clamp_high,
  input  logic [7:0]       empty_default,
  output mul_req_t         mreq,
  input  mul_rsp_t         mrsp,
  output logic             out_vld,
  input  logic             out_pop,
  output logic [7:0]       out_thr,
  output logic [CNT_W-1:0] out_cnt,
  output logic             out_emp
);

  localparam logic [3:0] S_ACC  = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_BIN  = 4'd2;
  localparam logic [3:0] S_MX   = 4'd3;
  localparam logic [3:0] S_MY   = 4'd4;
  localparam logic [3:0] S_D    = 4'd5;
  localparam logic [3:0] S_MN   = 4'd6;
  localparam logic [3:0] S_MDEN = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_ML   = 4'd9;
  localparam logic [3:0] S_MR   = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [CNT_W-1:0] mem [NUM_BINS];
  logic [CNT_W-1:0] rdata_r;
  logic [BIN_W-1:0] rd_addr;
  logic             mem_we;

  logic [3:0]          st_r, st_nxt;
  logic [NUM_BINS-1:0] vbit_r, vbit_nxt;
  logic                b_vld_r, b_vld_nxt;
  qent_t               b_ent_r;
  logic                wr_vld_r, wr_vld_nxt;
  logic [BIN_W-1:0]    wr_addr_r;
  logic [CNT_W-1:0]    wr_cnt_r, wr_cnt_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [BIN_W-1:0]    t_r, t_nxt;
  logic [CNT_W-1:0]    wb_r, wb_nxt;
  logic [CNT_W-1:0]    wf_r, wf_nxt;
  logic [SUM_W-1:0]    sb_r, sb_nxt;
  logic [XY_W-1:0]     x_r, x_nxt, y_r, y_nxt, d_r, d_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt, bnum_r, bnum_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt, bden_r, bden_nxt;
  logic [MP_W-1:0]     lhs_r, lhs_nxt;
  logic                have_r, have_nxt;
  logic [BIN_W-1:0]    bt_r, bt_nxt;
  logic                run_r, run_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [7:0]          out_thr_r, out_thr_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic                out_emp_r, out_emp_nxt;

  logic [CNT_W-1:0]         base;
  logic [CNT_W-1:0]         h;
  logic [CNT_W-1:0]         wbn;
  logic [CNT_W-1:0]         wfn;
  logic [BIN_W+CNT_W-1:0]   tmul;
  logic [7:0]               clo;
  logic [7:0]               chi;
  logic                     ld;
  logic                     take;
  logic                     step;

  assign out_vld = out_vld_r;
  assign out_thr = out_thr_r;
  assign out_cnt = out_cnt_r;
  assign out_emp = out_emp_r;

  assign q_pop = (st_r == S_ACC) && !q_empty && !(b_vld_r && b_ent_r.last);

  assign base = (wr_vld_r && (wr_addr_r == b_ent_r.lum)) ? wr_cnt_r :
                (vbit_r[b_ent_r.lum] ? rdata_r : '0);
  assign h    = vbit_r[t_r] ? rdata_r : '0;
  assign wbn  = wb_r + h;
  assign wfn  = total_r - wbn;
  assign tmul = t_r * h;
  assign clo  = (bt_r < clamp_low) ? clamp_low : bt_r;
  assign chi  = (clo > clamp_high) ? clamp_high : clo;
  assign ld   = (st_r == S_FIN) && (!out_vld_r || out_pop);

  always_comb begin
    rd_addr = (st_r == S_ACC) ? q_head.lum : t_r;
    mem_we  = (st_r == S_ACC) && b_vld_r && b_ent_r.vis;
  end

  always_comb begin
    st_nxt      = st_r;
    vbit_nxt    = vbit_r;
    b_vld_nxt   = q_pop;
    wr_vld_nxt  = wr_vld_r;
    wr_cnt_nxt  = base + 1'b1;
    total_nxt   = total_r;
    sum_nxt     = sum_r;
    t_nxt       = t_r;
    wb_nxt      = wb_r;
    wf_nxt      = wf_r;
    sb_nxt      = sb_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    d_nxt       = d_r;
    num_nxt     = num_r;
    bnum_nxt    = bnum_r;
    den_nxt     = den_r;
    bden_nxt    = bden_r;
    lhs_nxt     = lhs_r;
    have_nxt    = have_r;
    bt_nxt      = bt_r;
    run_nxt     = run_r;
    out_vld_nxt = (out_vld_r && out_pop) ? 1'b0 : out_vld_r;
    out_thr_nxt = out_thr_r;
    out_cnt_nxt = out_cnt_r;
    out_emp_nxt = out_emp_r;
    mreq.start  = 1'b0;
    mreq.a      = '0;
    mreq.b      = '0;
    take        = 1'b0;
    step        = 1'b0;

    unique case (st_r)
      S_ACC: begin
        if (b_vld_r) begin
          if (b_ent_r.vis) begin
            vbit_nxt[b_ent_r.lum] = 1'b1;
            wr_vld_nxt = 1'b1;
            total_nxt  = total_r + 1'b1;
            sum_nxt    = sum_r + SUM_W'(b_ent_r.lum);
          end
          if (b_ent_r.last) begin
            t_nxt    = '0;
            wb_nxt   = '0;
            sb_nxt   = '0;
            have_nxt = 1'b0;
            bt_nxt   = FALLBACK_T;
            st_nxt   = S_RD;
          end
        end
      end
      S_RD: begin
        st_nxt = (total_r == '0) ? S_FIN : S_BIN;
      end
      S_BIN: begin
        if (wbn == '0) begin
          step = 1'b1;
        end else if (wfn == '0) begin
          st_nxt = S_FIN;
        end else begin
          wb_nxt = wbn;
          wf_nxt = wfn;
          sb_nxt = sb_r + tmul[SUM_W-1:0];
          st_nxt = S_MX;
        end
      end
      S_MX: begin
        mreq.a = MA_W'(sb_r);
        mreq.b = MB_W'(total_r);
        if (!run_r) begin
          mreq.start = 1'b1;
          run_nxt    = 1'b1;
        end else if (mrsp.done) begin
          run_nxt = 1'b0;
          x_nxt   = mrsp.p[XY_W-1:0];
          st_nxt  = S_MY;
        end
      end
      S_MY: begin
        mreq.a = MA_W'(sum_r);
        mreq.b = MB_W'(wb_r);
        if (!run_r) begin
          mreq.start = 1'b1;
          run_nxt    = 1'b1;
        end else if (mrsp.done) begin
          run_nxt = 1'b0;
          y_nxt   = mrsp.p[XY_W-1:0];
          st_nxt  = S_D;
        end
      end
      S_D: begin
        d_nxt  = (x_r >= y_r) ? (x_r - y_r) : (y_r - x_r);
        st_nxt = S_MN;
      end
      S_MN: begin
        mreq.a = MA_W'(d_r);
        mreq.b = d_r;
        if (!run_r) begin
          mreq.start = 1'b1;
          run_nxt    = 1'b1;
        end else if (mrsp.done) begin
          run_nxt = 1'b0;
          num_nxt = mrsp.p[NUM_W-1:0];
          st_nxt  = S_MDEN;
        end
      end
      S_MDEN: begin
        mreq.a = MA_W'(wb_r);
        mreq.b = MB_W'(wf_r);
        if (!run_r) begin
          mreq.start = 1'b1;
          run_nxt    = 1'b1;
        end else if (mrsp.done) begin
          run_nxt = 1'b0;
          den_nxt = mrsp.p[DEN_W-1:0];
          st_nxt  = have_r ? S_ML : S_CMP;
        end
      end
      S_CMP: begin
        take = 1'b1;
        step = 1'b1;
      end
      S_ML: begin
        mreq.a = num_r;
        mreq.b = MB_W'(bden_r);
        if (!run_r) begin
          mreq.start = 1'b1;
          run_nxt    = 1'b1;
        end else if (mrsp.done) begin
          run_nxt = 1'b0;
          lhs_nxt = mrsp.p;
          st_nxt  = S_MR;
        end
      end
      S_MR: begin
        mreq.a = bnum_r;
        mreq.b = MB_W'(den_r);
        if (!run_r) begin
          mreq.start = 1'b1;
          run_nxt    = 1'b1;
        end else if (mrsp.done) begin
          run_nxt = 1'b0;
          take    = (lhs_r > mrsp.p);
          step    = 1'b1;
        end
      end
      S_FIN: begin
        if (ld) begin
          out_vld_nxt = 1'b1;
          out_emp_nxt = (total_r == '0);
          out_thr_nxt = (total_r == '0) ? empty_default : chi;
          out_cnt_nxt = total_r;
          total_nxt   = '0;
          sum_nxt     = '0;
          vbit_nxt    = '0;
          wr_vld_nxt  = 1'b0;
          st_nxt      = S_ACC;
        end
      end
      default: st_nxt = S_ACC;
    endcase

    if (take) begin
      bnum_nxt = num_r;
      bden_nxt = den_r;
      bt_nxt   = t_r;
      have_nxt = 1'b1;
    end
    if (step) begin
      if (t_r == 8'd255) begin
        st_nxt = S_FIN;
      end else begin
        t_nxt  = t_r + 1'b1;
        st_nxt = S_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_ACC;
      vbit_r    <= '0;
      b_vld_r   <= 1'b0;
      wr_vld_r  <= 1'b0;
      total_r   <= '0;
      sum_r     <= '0;
      run_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      vbit_r    <= vbit_nxt;
      b_vld_r   <= b_vld_nxt;
      wr_vld_r  <= wr_vld_nxt;
      total_r   <= total_nxt;
      sum_r     <= sum_nxt;
      run_r     <= run_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_ent_r   <= q_head;
    if (mem_we) begin
      wr_addr_r <= b_ent_r.lum;
      wr_cnt_r  <= wr_cnt_nxt;
    end
    t_r       <= t_nxt;
    wb_r      <= wb_nxt;
    wf_r      <= wf_nxt;
    sb_r      <= sb_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    d_r       <= d_nxt;
    num_r     <= num_nxt;
    bnum_r    <= bnum_nxt;
    den_r     <= den_nxt;
    bden_r    <= bden_nxt;
    lhs_r     <= lhs_nxt;
    have_r    <= have_nxt;
    bt_r      <= bt_nxt;
    out_thr_r <= out_thr_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_emp_r <= out_emp_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[b_ent_r.lum] <= wr_cnt_nxt;
    rdata_r <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_no_pop_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_ACC) |-> !q_pop) else $error("queue popped during search");
  a_clear_after_image: assert property (@(posedge clk) disable iff (!rst_n)
    ld |=> ((total_r == '0) && (vbit_r == '0))) else $error("image state not cleared");
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_emp_r) |-> (out_cnt_r == '0)) else $error("empty result with count");
  a_mul_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.start |-> !mrsp.busy) else $error("multiplier started while busy");
`endif

endmodule
